// ----- sv/moving_average_sma_ema_macros.svh -----
// Assertion helpers shared by the checker.
`ifndef MOVING_AVERAGE_SMA_EMA_MACROS_SVH
`define MOVING_AVERAGE_SMA_EMA_MACROS_SVH

// Clocked property, skipped while reset is held.
`define MASE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define MASE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/mase_pkg.sv -----
package mase_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int LEN_W      = 9;
    localparam int FACTOR_W   = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int MEAN_W     = 32;
    localparam int EMA_OUT_W  = 48;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_FACTOR = 2'd1;

    localparam logic [LEN_W-1:0]    WINDOW_LENGTH_RST = 9'd5;
    localparam logic [FACTOR_W-1:0] FACTOR_RST        = 17'd21845;
    localparam logic [FACTOR_W-1:0] ONE_Q16           = 17'd65536;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic upd;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// ----- sv/mase_if.sv -----
interface mase_in_if #(
    parameter int SAMPLE_BITS = 32
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   series_start;

    modport source (output valid, output sample, output series_start, input ready);
    modport sink   (input valid, input sample, input series_start, output ready);
endinterface

interface mase_out_if ();
    import mase_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [MEAN_W-1:0]    mean_value;
    logic                 mean_valid;
    logic [EMA_OUT_W-1:0] ema_value;

    modport source (output valid, output mean_value, output mean_valid, output ema_value,
                    input ready);
    modport sink   (input valid, input mean_value, input mean_valid, input ema_value,
                    output ready);
endinterface

interface mase_cfg_if ();
    import mase_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/mase_ctrl.sv -----
module mase_ctrl #(
    parameter int DIV_STEPS = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mase_pkg::t_status i_status,
    output mase_pkg::t_cmd    o_cmd
);
    import mase_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_DLOAD = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DLOAD;
            end
            S_DLOAD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = CNT_W'(DIV_STEPS - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- sv/mase_dp.sv -----
module mase_dp #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mase_pkg::t_cmd                  i_cmd,
    output mase_pkg::t_status               o_status,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic                            i_series_start,
    input  logic                            i_cfg_write,
    input  logic [mase_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mase_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [mase_pkg::MEAN_W-1:0]     o_mean_value,
    output logic                            o_mean_valid,
    output logic [mase_pkg::EMA_OUT_W-1:0]  o_ema_value
);
    import mase_pkg::*;

    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int AEXT_W = IDX_W + 1;
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int EMA_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int PHI_W  = SAMPLE_BITS + FACTOR_W;
    localparam int PLO_W  = FRAC_BITS + FACTOR_W;

    // configuration
    logic [LEN_W-1:0]    r_window_length;
    logic [FACTOR_W-1:0] r_factor;
    logic [LEN_W-1:0]    eff_len;
    logic [FACTOR_W-1:0] eff_factor;

    // series state
    logic [SAMPLE_BITS-1:0] r_ring [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] r_ring_q;
    logic [IDX_W-1:0]       r_slot;
    logic [LEN_W-1:0]       r_fill;
    logic [SUM_W-1:0]       r_sum;
    logic [EMA_W-1:0]       r_ema;
    logic                   r_primed;

    // per-item working registers
    logic [SAMPLE_BITS-1:0] r_x;
    logic                   r_start;
    logic                   r_up;
    logic [EMA_W-1:0]       r_diff;
    logic [PHI_W-1:0]       r_prod_hi;
    logic [PLO_W-1:0]       r_prod_lo;
    logic [SUM_W-1:0]       r_quot;
    logic [LEN_W-1:0]       r_rem;
    logic                   r_out_valid;

    logic [EMA_W-1:0]  x16;
    logic [AEXT_W-1:0] old_ext;
    logic [IDX_W-1:0]  old_addr;
    logic [IDX_W-1:0]  next_slot;
    logic [PHI_W-1:0]  ema_inc;
    logic [SUM_W-1:0]  sum_kept;
    logic [LEN_W:0]    rem_sh;
    logic              rem_ge;

    always_comb begin
        if (r_window_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(r_window_length) > 32'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = r_window_length;
        end
        eff_factor = (r_factor > ONE_Q16) ? ONE_Q16 : r_factor;
    end

    assign x16 = {i_sample, {FRAC_BITS{1'b0}}};

    // slot of the sample that leaves the window: slot - len, modulo depth
    always_comb begin
        old_ext = {1'b0, r_slot} + AEXT_W'(MAX_WINDOW) - AEXT_W'(eff_len);
        if (old_ext >= AEXT_W'(MAX_WINDOW)) begin
            old_ext = old_ext - AEXT_W'(MAX_WINDOW);
        end
        old_addr = old_ext[IDX_W-1:0];
    end

    assign next_slot = (32'(r_slot) == MAX_WINDOW - 1) ? '0 : r_slot + 1'b1;
    assign ema_inc   = r_prod_hi + PHI_W'(r_prod_lo[PLO_W-1:FRAC_BITS]);
    assign sum_kept  = (r_fill >= eff_len) ? (r_sum - SUM_W'(r_ring_q)) : r_sum;

    assign rem_sh = {r_rem, r_quot[SUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, eff_len};

    // ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_ring[r_slot] <= r_x;
        end
        if (i_cmd.accept) begin
            r_ring_q <= r_ring[old_addr];
        end
    end

    // configuration and series state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_LENGTH_RST;
            r_factor        <= FACTOR_RST;
            r_slot          <= '0;
            r_fill          <= '0;
            r_sum           <= '0;
            r_ema           <= '0;
            r_primed        <= 1'b0;
        end else begin
            if (i_cfg_write) begin
                case (i_cfg_index)
                    REG_WINDOW_LENGTH: begin
                        r_window_length <= i_cfg_data[LEN_W-1:0];
                        r_fill          <= '0;
                        r_sum           <= '0;
                    end
                    REG_SMOOTHING_FACTOR: begin
                        r_factor <= i_cfg_data[FACTOR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.upd) begin
                r_primed <= 1'b1;
                r_slot   <= next_slot;
                if (r_start) begin
                    r_ema  <= {r_x, {FRAC_BITS{1'b0}}};
                    r_sum  <= SUM_W'(r_x);
                    r_fill <= LEN_W'(1);
                end else begin
                    r_ema <= r_up ? (r_ema + EMA_W'(ema_inc)) : (r_ema - EMA_W'(ema_inc));
                    r_sum <= sum_kept + SUM_W'(r_x);
                    if (r_fill < eff_len) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end
            end
        end
    end

    // per-item arithmetic
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x     <= i_sample;
            r_start <= i_series_start || !r_primed;
            r_up    <= x16 >= r_ema;
            r_diff  <= (x16 >= r_ema) ? (x16 - r_ema) : (r_ema - x16);
        end
        if (i_cmd.mul) begin
            r_prod_hi <= PHI_W'(r_diff[EMA_W-1:FRAC_BITS]) * PHI_W'(eff_factor);
            r_prod_lo <= PLO_W'(r_diff[FRAC_BITS-1:0]) * PLO_W'(eff_factor);
        end
        if (i_cmd.div_load) begin
            r_quot <= r_sum;
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[SUM_W-2:0], rem_ge};
            r_rem  <= rem_ge ? LEN_W'(rem_sh - {1'b0, eff_len}) : LEN_W'(rem_sh);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_mean_valid <= r_fill >= eff_len;
            o_mean_value <= (r_fill >= eff_len) ? MEAN_W'(r_quot) : '0;
            o_ema_value  <= EMA_OUT_W'(r_ema);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

// ----- sv/moving_average_sma_ema.sv -----
// Simple and exponential moving average of an unsigned sample stream.
//
// Channels: i_in carries one sample and a series_start flag per transfer;
// o_out returns one result per sample (windowed mean, its valid flag and
// the EMA in Q.16); i_cfg writes window_length (index 0, restarts the
// window) and smoothing_factor (index 1); i_cfg is always ready. The user
// writes i_cfg only while no sample is in flight; the block does not check.
//
// Flow: after the input transfer a sample passes the states MUL (EMA
// product), UPD (ring, sum and EMA update), DLOAD and DIV (the restoring
// divider of the mean over the SUM_W-bit running sum, one quotient bit per
// cycle) and OUT, where it waits for the output register. One sample is
// worked on at a time, so the next input transfer is taken only after the
// last result has been loaded into the output register.
//
// Reset: synchronous, active low; registers go to their reset values, the
// first sample after reset starts a series. The ring memory needs no clear.
// Stall: a finished result waits in the output register; the next sample is
// taken meanwhile and runs until its own result is due, then holds there.
module moving_average_sma_ema #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input logic        i_clk,
    input logic        i_rst_n,
    mase_in_if.sink    i_in,
    mase_out_if.source o_out,
    mase_cfg_if.sink   i_cfg
);
    import mase_pkg::*;

    // running sum sets the divider length
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready  = w_in_ready;
    // registers take a write in any cycle
    assign i_cfg.ready = 1'b1;

    mase_ctrl #(
        .DIV_STEPS (SUM_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mase_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_sample       (i_in.sample),
        .i_series_start (i_in.series_start),
        .i_cfg_write    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_mean_value   (o_out.mean_value),
        .o_mean_valid   (o_out.mean_valid),
        .o_ema_value    (o_out.ema_value)
    );

endmodule

// ----- sv/mase_checker.sv -----
`include "moving_average_sma_ema_macros.svh"

module mase_props (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_cfg_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [mase_pkg::MEAN_W-1:0]    i_mean_value,
    input logic                           i_mean_valid,
    input logic [mase_pkg::EMA_OUT_W-1:0] i_ema_value
);

    // one sample at a time: no transfer right after a transfer
    `MASE_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "input taken while busy")

    // a result never appears the cycle after its sample was taken
    `MASE_ASSERT(a_min_latency, i_clk, i_rst_n, $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready), "result too early")

    // mean reads zero until the window has filled
    `MASE_ASSERT(a_mean_zero, i_clk, i_rst_n, (i_out_valid && !i_mean_valid) |-> (i_mean_value == '0), "mean not zero while invalid")

    // a stalled result holds
    `MASE_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_mean_value) && $stable(i_mean_valid) && $stable(i_ema_value)), "stalled result changed")

    // register port never stalls
    `MASE_ASSERT_ALWAYS(a_cfg_ready, i_clk, i_cfg_ready, "config port stalled")

endmodule

bind moving_average_sma_ema mase_props u_mase_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_cfg_ready  (i_cfg.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_mean_value (o_out.mean_value),
    .i_mean_valid (o_out.mean_valid),
    .i_ema_value  (o_out.ema_value)
);

// ----- test/mase_checker.sv -----
module mase_checker #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mase_in_if   i_in_mon,
    mase_out_if  i_out_mon,
    mase_cfg_if  i_cfg_mon,
    output int   o_errors,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mase_pkg::*;

    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + SLOT_W;
    localparam int ACC_W  = SAMPLE_BITS + FRAC_BITS;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [MEAN_W-1:0]    mean;
        logic                 valid;
        logic [EMA_OUT_W-1:0] ema;
    } t_average;

    t_average averages_due[$];

    logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    logic [SLOT_W-1:0]      slot;
    logic [LEN_W-1:0]       fill;
    logic [SUM_W-1:0]       sum;
    logic [ACC_W-1:0]       ema;
    logic                   primed;
    logic [LEN_W-1:0]       win_len;
    logic [FACTOR_W-1:0]    factor;

    // floor(d * a / 2^16), split so the product cannot overflow
    function automatic logic [63:0] scale_q16(input logic [63:0] d, input logic [63:0] a);
        return (d >> FRAC_BITS) * a + (((d & 64'hFFFF) * a) >> FRAC_BITS);
    endfunction

    function automatic t_average next_average(input logic [SAMPLE_BITS-1:0] x,
                                              input logic start);
        int unsigned len;
        int unsigned old;
        logic [63:0] x16;
        logic [63:0] a;
        t_average    r;
        len = (win_len == '0) ? 1 : (win_len > MAX_WINDOW) ? MAX_WINDOW : win_len;
        a   = (factor > ONE_Q16) ? 64'(ONE_Q16) : 64'(factor);
        x16 = 64'(x) << FRAC_BITS;
        if (start || !primed) begin
            fill   = '0;
            sum    = '0;
            ema    = ACC_W'(x16);
            primed = 1'b1;
        end else if (x16 >= 64'(ema)) begin
            ema = ema + ACC_W'(scale_q16(x16 - 64'(ema), a));
        end else begin
            ema = ema - ACC_W'(scale_q16(64'(ema) - x16, a));
        end
        // oldest sample leaves before its slot is reused
        if (fill >= len) begin
            old = (int'(slot) + MAX_WINDOW - len) % MAX_WINDOW;
            sum = sum - SUM_W'(ring[old]);
        end
        ring[slot] = x;
        sum  = sum + SUM_W'(x);
        slot = SLOT_W'((int'(slot) + 1) % MAX_WINDOW);
        if (fill < len) fill = fill + 1'b1;
        r.valid = (fill >= len);
        r.mean  = r.valid ? MEAN_W'(64'(sum) / 64'(len)) : '0;
        r.ema   = EMA_OUT_W'(ema);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_average got;
        t_average want;
        t_average pred;
        if (!i_rst_n) begin
            averages_due.delete();
            slot      = '0;
            fill      = '0;
            sum       = '0;
            ema       = '0;
            primed    = 1'b0;
            win_len   = WINDOW_LENGTH_RST;
            factor    = FACTOR_RST;
            o_errors  = 0;
            o_pending = 0;
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready) begin
                case (i_cfg_mon.index)
                    REG_WINDOW_LENGTH: begin
                        win_len = i_cfg_mon.data[LEN_W-1:0];
                        fill    = '0;
                        sum     = '0;
                    end
                    REG_SMOOTHING_FACTOR: begin
                        factor = i_cfg_mon.data[FACTOR_W-1:0];
                    end
                    default: ;
                endcase
            end
            // results first: a result never belongs to a sample of the same edge
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.mean  = i_out_mon.mean_value;
                got.valid = i_out_mon.mean_valid;
                got.ema   = i_out_mon.ema_value;
                if (averages_due.size() == 0) begin
                    if (o_errors < REPORT_MAX)
                        $display("unexpected result: mean %h valid %b ema %h",
                                 got.mean, got.valid, got.ema);
                    o_errors++;
                end else begin
                    want = averages_due.pop_front();
                    if (got.mean !== want.mean || got.valid !== want.valid ||
                        got.ema !== want.ema) begin
                        if (o_errors < REPORT_MAX)
                            $display("mismatch: mean exp %h got %h, valid exp %b got %b, ema exp %h got %h",
                                     want.mean, got.mean, want.valid, got.valid,
                                     want.ema, got.ema);
                        o_errors++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                pred         = next_average(i_in_mon.sample, i_in_mon.series_start);
                averages_due = {averages_due, pred};
            end
            o_pending = averages_due.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mase_pkg::*;

    localparam int MAX_WINDOW   = 256;
    localparam int SAMPLE_BITS  = 32;
    localparam int CLK_HALF     = 4;          // 8 ns period
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 100;
    // Slowest honest item: its work plus the longest sender gap and the longest
    // receiver stall; for all the items of the run this limit is ample.
    localparam int CYCLE_LIMIT  = 2_000_000;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SRC_IDLE,
        PACE_SNK_STALL,
        PACE_BOTH
    } t_pace;

    logic i_clk;
    logic i_rst_n;

    mase_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    mase_out_if                             out_ch ();
    mase_cfg_if                             cfg_ch ();

    int errors;
    int pending_cnt;

    // percentage of cycles the sender idles / the receiver refuses a transfer
    int src_idle_pct;
    int snk_stall_pct;

    logic [SAMPLE_BITS-1:0] last_sample;

    moving_average_sma_ema #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    // The checker sees every transfer on all three channels, keeps its own
    // copy of the averaging state and scores the results.
    mase_checker #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_mon (in_ch),
        .i_out_mon(out_ch),
        .i_cfg_mon(cfg_ch),
        .o_errors (errors),
        .o_pending(pending_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: ready changes only on the falling edge. Besides the per-cycle
    // coin, an occasional long stall lets a finished result sit in the output
    // register while the next sample is already being worked on.
    initial begin
        int hold;
        hold = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else if (snk_stall_pct != 0 && $urandom_range(0, 63) == 0) begin
                hold = $urandom_range(1, 120);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    function automatic void set_pace(input t_pace pace);
        case (pace)
            PACE_FREE: begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            PACE_SRC_IDLE: begin
                src_idle_pct  = 52;
                snk_stall_pct = 0;
            end
            PACE_SNK_STALL: begin
                src_idle_pct  = 0;
                snk_stall_pct = 52;
            end
            default: begin
                src_idle_pct  = 19;
                snk_stall_pct = 19;
            end
        endcase
    endfunction

    // Drop valid and wait until every sample sent so far has its result back.
    // Each sample always gives exactly one result, so the block is idle then.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_cnt != 0) @(negedge i_clk);
    endtask

    // One register write, only ever done with the sample path drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!(cfg_ch.valid && cfg_ch.ready)) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Offer one sample, holding it until the transfer. Called and left on a
    // falling edge; valid is only touched once per time step.
    task automatic push_sample(input logic [SAMPLE_BITS-1:0] value, input logic start);
        int gap;
        gap = 0;
        if (src_idle_pct != 0 && $urandom_range(0, 15) == 0)
            gap = $urandom_range(1, 120);       // long enough to straddle a whole item
        else
            while ($urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample       <= value;
        in_ch.series_start <= start;
        @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready)) @(posedge i_clk);
        @(negedge i_clk);
        last_sample = value;
    endtask

    // Mix of extremes, small values, values close to the previous one (small
    // EMA steps, including the round-to-zero case) and full-range noise.
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_BITS'($urandom_range(0, 255));
            3:       return {{(SAMPLE_BITS-8){1'b1}}, 8'($urandom)};
            4, 5:    return last_sample + SAMPLE_BITS'($urandom_range(0, 64)) - 32;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // A phase: program both registers, then stream random samples. Series
    // starts are kept rare against the window length so the mean gets valid;
    // noisy phases restart the series often to hammer the clear path.
    task automatic run_phase(input logic [LEN_W-1:0] len, input logic [FACTOR_W-1:0] fac,
                             input t_pace pace, input int count, input logic noisy);
        int unsigned eff_len;
        int unsigned span;
        eff_len = (len == '0) ? 1 : (len > MAX_WINDOW) ? MAX_WINDOW : len;
        span    = noisy ? 7 : 4 * eff_len + 8;
        // upper data bits are junk for the window register and must be ignored
        write_reg(REG_WINDOW_LENGTH, {8'($urandom), len});
        write_reg(REG_SMOOTHING_FACTOR, fac);
        set_pace(pace);
        repeat (count) push_sample(pick_sample(), $urandom_range(0, span) == 0);
    endtask

    initial begin
        logic [LEN_W-1:0] rnd_len;
        in_ch.valid        = 1'b0;
        in_ch.sample       = '0;
        in_ch.series_start = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_WINDOW_LENGTH;
        cfg_ch.data        = '0;
        last_sample        = '0;
        i_rst_n            = 1'b0;
        set_pace(PACE_FREE);
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed, reset settings (window 5, factor 1/3) ----
        // first sample after reset must seed the series without the flag
        push_sample('0, 1'b0);
        repeat (5) push_sample('1, 1'b0);       // full-scale window sum
        push_sample('0, 1'b0);                  // largest downward EMA step
        push_sample('1, 1'b1);                  // restart mid-stream
        push_sample(32'd1, 1'b0);
        push_sample(32'h8000_0000, 1'b0);

        // window zero behaves as one; factor above one behaves as one
        write_reg(REG_WINDOW_LENGTH, 17'd0);
        write_reg(REG_SMOOTHING_FACTOR, 17'h1FFFF);
        push_sample(32'd123, 1'b0);
        push_sample('1, 1'b0);
        push_sample('0, 1'b0);

        // window above the ring size clamps; factor zero freezes the EMA
        write_reg(REG_WINDOW_LENGTH, 17'h1FF);
        write_reg(REG_SMOOTHING_FACTOR, 17'd0);
        push_sample(32'd7, 1'b1);
        push_sample('1, 1'b0);
        push_sample('0, 1'b0);

        // writes to unused indexes must leave everything alone
        write_reg(REG_SPARE_A, 17'h1FFFF);
        write_reg(REG_SPARE_B, 17'd0);
        // exactly one in Q1.16; a window write restarts the mean, not the EMA
        write_reg(REG_SMOOTHING_FACTOR, ONE_Q16);
        write_reg(REG_WINDOW_LENGTH, 17'd2);
        push_sample(32'd5, 1'b0);
        push_sample(32'hFFFF_FFFE, 1'b0);
        push_sample(32'd3, 1'b1);

        // smallest non-zero factor: steps mostly truncate to nothing
        write_reg(REG_SMOOTHING_FACTOR, 17'd1);
        write_reg(REG_WINDOW_LENGTH, 17'd3);
        push_sample('1, 1'b0);
        push_sample('0, 1'b0);
        push_sample('0, 1'b0);

        // ---- random phases over a spread of settings and pacing ----
        run_phase(WINDOW_LENGTH_RST, FACTOR_RST, PACE_FREE, 200, 1'b0);
        run_phase(9'd1, ONE_Q16, PACE_SRC_IDLE, 150, 1'b0);
        run_phase(9'd256, 17'd1, PACE_SNK_STALL, 320, 1'b0);
        run_phase(9'h1FF, 17'h1FFFF, PACE_BOTH, 100, 1'b0);
        run_phase(9'd0, 17'd0, PACE_FREE, 80, 1'b0);
        run_phase(9'd16, 17'd13107, PACE_BOTH, 200, 1'b0);   // period 9
        run_phase(9'd3, 17'd32768, PACE_SNK_STALL, 150, 1'b1);
        repeat (6) begin
            // mostly short windows so the mean gets valid; now and then any value
            if ($urandom_range(0, 3) == 0) rnd_len = LEN_W'($urandom);
            else rnd_len = LEN_W'($urandom_range(1, 32));
            run_phase(rnd_len, FACTOR_W'($urandom), t_pace'($urandom_range(0, 3)), 100,
                      $urandom_range(0, 3) == 0);
        end

        // ---- drain and verdict ----
        settle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (errors == 0 && pending_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
